/* src/mask_shadow_projection_defines.svh */
// Assertion macros for the mask shadow projection block.
`ifndef MASK_SHADOW_PROJECTION_DEFINES_SVH
`define MASK_SHADOW_PROJECTION_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define MSP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies another after the delay given as n.
`define MSP_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");
`else
`define MSP_ASSERT_IMPL(lbl, ante, cons)
`define MSP_ASSERT_DELAY(lbl, ante, n, cons)
`endif

`endif

/* src/msp_pkg.sv */
package msp_pkg;

    // Default geometry
    localparam int DEF_DET_COLS  = 256;
    localparam int DEF_DET_ROWS  = 256;
    localparam int DEF_MASK_COLS = 512;
    localparam int DEF_MASK_ROWS = 512;

    // Datapath widths
    localparam int P2_W  = 36;   // signed doubled position
    localparam int POS_W = 35;   // non-negative doubled position
    localparam int PER_W = 34;   // doubled gap pattern values
    localparam int W2_W  = 38;   // doubled detector width and divisor shifts

    // Axis latency: product, range check, one stage per position bit, gap check
    localparam int AX_LAT = POS_W + 3;

    // Register indexes
    localparam logic [2:0] REG_PITCH_X     = 3'd0;
    localparam logic [2:0] REG_PITCH_Y     = 3'd1;
    localparam logic [2:0] REG_OFFSET_X    = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd3;
    localparam logic [2:0] REG_UNIT_LENGTH = 3'd4;
    localparam logic [2:0] REG_UNIT_GAP    = 3'd5;
    localparam logic [2:0] REG_MODULE_GAP  = 3'd6;

    // Gap pattern, all values doubled
    typedef struct packed {
        logic             en;
        logic [PER_W-1:0] u2;
        logic [PER_W-1:0] ug2;
        logic [PER_W-1:0] len2;
        logic [PER_W-1:0] per2;
    } gap_cfg_t;

endpackage

/* src/mask_shadow_projection.sv */
// Channel   | Handshake         | Payload
// ----------+-------------------+---------------------------------------------
// input     | start / busy      | mask_col, mask_row, transparency
// result    | done (strobe)     | det_col, det_row, hit, shadow_value
// config    | cfg_we            | cfg_addr, cfg_data
//
// One item is taken every cycle; busy stays low. Each result is transferred
// after its input passes the input register, the axis pipelines with their
// bit-serial modulo chain, one stage per position bit, and the output stage.
// Reset clears all valid bits and loads the register defaults. The receiver
// cannot stall, so the pipeline never holds.
`include "mask_shadow_projection_defines.svh"

module mask_shadow_projection import msp_pkg::*; #(
    parameter int DET_COLS  = DEF_DET_COLS,
    parameter int DET_ROWS  = DEF_DET_ROWS,
    parameter int MASK_COLS = DEF_MASK_COLS,
    parameter int MASK_ROWS = DEF_MASK_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [8:0]  mask_col,
    input  logic [8:0]  mask_row,
    input  logic [15:0] transparency,
    output logic        done,
    output logic [7:0]  det_col,
    output logic [7:0]  det_row,
    output logic        hit,
    output logic [15:0] shadow_value,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    localparam int QWX = (DET_COLS > 1) ? $clog2(DET_COLS) : 1;
    localparam int QWY = (DET_ROWS > 1) ? $clog2(DET_ROWS) : 1;

    logic [23:0]        pitch_x_reg, pitch_y_reg;
    logic signed [31:0] offset_x_reg, offset_y_reg;
    logic [29:0]        unit_length_reg, unit_gap_reg, module_gap_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_x_reg     <= 24'd250000;
            pitch_y_reg     <= 24'd250000;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            unit_length_reg <= '0;
            unit_gap_reg    <= '0;
            module_gap_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PITCH_X:     pitch_x_reg     <= cfg_data[23:0];
                REG_PITCH_Y:     pitch_y_reg     <= cfg_data[23:0];
                REG_OFFSET_X:    offset_x_reg    <= signed'(cfg_data);
                REG_OFFSET_Y:    offset_y_reg    <= signed'(cfg_data);
                REG_UNIT_LENGTH: unit_length_reg <= cfg_data[29:0];
                REG_UNIT_GAP:    unit_gap_reg    <= cfg_data[29:0];
                REG_MODULE_GAP:  module_gap_reg  <= cfg_data[29:0];
                default:         ;
            endcase
        end
    end

    // Doubled gap pattern, static between writes
    gap_cfg_t gap;
    always_comb
    begin
        gap.en   = (unit_length_reg != '0);
        gap.u2   = PER_W'({unit_length_reg, 1'b0});
        gap.ug2  = gap.u2 + PER_W'({unit_gap_reg, 1'b0});
        gap.len2 = gap.ug2 + gap.u2;
        gap.per2 = gap.len2 + PER_W'({module_gap_reg, 1'b0});
    end

    // Input stage
    logic        vld_in_reg;
    logic [8:0]  col_reg, row_reg;
    logic [15:0] tr_reg;
    logic        inr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_in_reg <= 1'b0;
        end
        else
        begin
            vld_in_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= mask_col;
        row_reg <= mask_row;
        tr_reg  <= transparency;
    end

    assign inr_next = (32'(col_reg) < MASK_COLS) && (32'(row_reg) < MASK_ROWS);

    // Axis pipelines
    logic           ok_x, ok_y;
    logic [QWX-1:0] pix_x;
    logic [QWY-1:0] pix_y;

    msp_axis #(.CELLS(DET_COLS), .QW(QWX)) u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .idx    (col_reg),
        .pitch  (pitch_x_reg),
        .offset (offset_x_reg),
        .gap    (gap),
        .ok     (ok_x),
        .pix    (pix_x)
    );

    msp_axis #(.CELLS(DET_ROWS), .QW(QWY)) u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .idx    (row_reg),
        .pitch  (pitch_y_reg),
        .offset (offset_y_reg),
        .gap    (gap),
        .ok     (ok_y),
        .pix    (pix_y)
    );

    // Carry valid, range flag and transparency alongside the axes
    logic [AX_LAT-1:0] vld_pipe_reg;
    logic [AX_LAT-1:0] inr_pipe_reg;
    logic [15:0]       tr_pipe_reg [AX_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else
        begin
            vld_pipe_reg <= {vld_pipe_reg[AX_LAT-2:0], vld_in_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        inr_pipe_reg   <= {inr_pipe_reg[AX_LAT-2:0], inr_next};
        tr_pipe_reg[0] <= tr_reg;
        for (int k = 1; k < AX_LAT; k++)
        begin
            tr_pipe_reg[k] <= tr_pipe_reg[k-1];
        end
    end

    // Output stage
    logic        done_reg, hit_reg, hit_next;
    logic [7:0]  col_out_reg, row_out_reg;
    logic [15:0] val_out_reg;

    assign hit_next = inr_pipe_reg[AX_LAT-1] && ok_x && ok_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_pipe_reg[AX_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        col_out_reg <= hit_next ? 8'(pix_x) : 8'd0;
        row_out_reg <= hit_next ? 8'(pix_y) : 8'd0;
        val_out_reg <= hit_next ? tr_pipe_reg[AX_LAT-1] : 16'd0;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign det_col      = col_out_reg;
    assign det_row      = row_out_reg;
    assign shadow_value = val_out_reg;

    localparam int TOTAL_LAT = AX_LAT + 2;

    `MSP_ASSERT_DELAY(a_result_follows, start, TOTAL_LAT, done)
    `MSP_ASSERT_IMPL(a_miss_clean, done && !hit, {det_col, det_row, shadow_value} == 32'd0)
    `MSP_ASSERT_IMPL(a_no_stray_done, done, $past(vld_pipe_reg[AX_LAT-1]))

endmodule

/* src/msp_axis.sv */
module msp_axis import msp_pkg::*; #(
    parameter int CELLS = DEF_DET_COLS,
    parameter int QW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [8:0]        idx,
    input  logic [23:0]       pitch,
    input  logic signed [31:0] offset,
    input  gap_cfg_t          gap,
    output logic              ok,
    output logic [QW-1:0]     pix
);

    localparam int STEPS = POS_W;

    logic signed [P2_W-1:0] p2_reg;
    logic signed [P2_W-1:0] p2_next;
    logic [33:0]            prod;

    logic [POS_W-1:0] pos_reg [STEPS+1];
    logic [PER_W-1:0] rm_reg  [STEPS+1];
    logic [POS_W-1:0] dr_reg  [STEPS+1];
    logic [QW-1:0]    q_reg   [STEPS+1];
    logic [STEPS:0]   ok_reg;

    logic [W2_W-1:0]  width2;
    logic             ok0_next;
    logic             ok_out_reg;
    logic             ok_out_next;
    logic [QW-1:0]    pix_reg;
    logic [PER_W-1:0] rfin;

    // Doubled position: (2*idx+1)*pitch + 2*offset
    assign prod    = 34'({idx, 1'b1}) * 34'(pitch);
    assign p2_next = signed'(P2_W'(prod)) + (P2_W'(offset) <<< 1);

    always_ff @(posedge clk)
    begin
        p2_reg <= p2_next;
    end

    // Drop negative, out-of-width and zero-pitch positions
    assign width2   = (W2_W'(pitch) * W2_W'(CELLS)) << 1;
    assign ok0_next = !p2_reg[P2_W-1] && (pitch != '0)
                      && (W2_W'(p2_reg[POS_W-1:0]) < width2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg[0] <= 1'b0;
        end
        else
        begin
            ok_reg[0] <= ok0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg[0] <= p2_reg[POS_W-1:0];
        rm_reg[0]  <= '0;
        dr_reg[0]  <= p2_reg[POS_W-1:0];
        q_reg[0]   <= '0;
    end

    // One modulo step per stage, and one quotient bit in each of the first QW stages
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [PER_W:0]   rsh;
        logic [PER_W-1:0] rm_next;
        logic [POS_W-1:0] dr_next;
        logic [QW-1:0]    q_next;

        assign rsh     = {rm_reg[k], pos_reg[k][POS_W-1-k]};
        assign rm_next = (rsh >= {1'b0, gap.per2}) ? PER_W'(rsh - {1'b0, gap.per2})
                                                   : PER_W'(rsh);

        if (k < QW)
        begin : g_div
            logic [W2_W-1:0] dsh;
            assign dsh = W2_W'(pitch) << (QW - k);
            always_comb
            begin
                dr_next = dr_reg[k];
                q_next  = q_reg[k];
                if (W2_W'(dr_reg[k]) >= dsh)
                begin
                    dr_next = POS_W'(W2_W'(dr_reg[k]) - dsh);
                    q_next[QW-1-k] = 1'b1;
                end
            end
        end
        else
        begin : g_hold
            assign dr_next = dr_reg[k];
            assign q_next  = q_reg[k];
        end

        always_ff @(posedge clk)
        begin
            pos_reg[k+1] <= pos_reg[k];
            rm_reg[k+1]  <= rm_next;
            dr_reg[k+1]  <= dr_next;
            q_reg[k+1]   <= q_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ok_reg[k+1] <= 1'b0;
            end
            else
            begin
                ok_reg[k+1] <= ok_reg[k];
            end
        end
    end

    // Drop positions that fall in a unit or module gap
    assign rfin        = rm_reg[STEPS];
    assign ok_out_next = ok_reg[STEPS]
                         && (!gap.en || (rfin < gap.u2)
                             || ((rfin > gap.ug2) && (rfin < gap.len2)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_out_reg <= 1'b0;
        end
        else
        begin
            ok_out_reg <= ok_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= q_reg[STEPS];
    end

    assign ok  = ok_out_reg;
    assign pix = pix_reg;

endmodule

/* tb/mask_shadow_projection_tb.sv */
module mask_shadow_projection_tb;
    import msp_pkg::*;

    localparam int LATENCY   = AX_LAT + 2;
    localparam int WD_LIMIT  = 2000;
    localparam int DET_SIZE  = 256;
    localparam int MASK_SIZE = 512;

    typedef struct packed {
        logic [7:0]  col;
        logic [7:0]  row;
        logic        hit;
        logic [15:0] value;
    } shadow_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [8:0]  mask_col;
    logic [8:0]  mask_row;
    logic [15:0] transparency;
    logic        done;
    logic [7:0]  det_col;
    logic [7:0]  det_row;
    logic        hit;
    logic [15:0] shadow_value;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;

    // Shadow copy of the register file
    logic [23:0]        m_pitch_x;
    logic [23:0]        m_pitch_y;
    logic signed [31:0] m_off_x;
    logic signed [31:0] m_off_y;
    logic [29:0]        m_unit_len;
    logic [29:0]        m_unit_gap;
    logic [29:0]        m_mod_gap;

    shadow_t     expected_shadows[$];
    int          mismatches;
    int          hits_seen;
    int          shadows_seen;
    int          items_sent;
    int          idle_cycles;
    bit          allow_gaps;
    bit          timed_out;

    mask_shadow_projection uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mask_col(mask_col), .mask_row(mask_row), .transparency(transparency),
        .done(done), .det_col(det_col), .det_row(det_row), .hit(hit),
        .shadow_value(shadow_value), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Project one axis in doubled units; returns hit and writes the pixel
    function automatic bit axis_shadow(input logic [8:0] idx, input logic [23:0] pitch,
                                       input logic signed [31:0] off,
                                       output logic [7:0] pix);
        longint p2;
        longint width2;
        longint u2;
        longint g2;
        longint len2;
        longint per2;
        longint r;
        pix = 0;
        p2 = (2 * longint'(idx) + 1) * longint'(pitch) + 2 * longint'(off);
        if (p2 < 0 || pitch == 0)
            return 0;
        width2 = 2 * DET_SIZE * longint'(pitch);
        if (p2 >= width2)
            return 0;
        if (m_unit_len != 0)
        begin
            u2 = 2 * longint'(m_unit_len);
            g2 = 2 * longint'(m_unit_gap);
            len2 = 2 * u2 + g2;
            per2 = len2 + 2 * longint'(m_mod_gap);
            r = p2 % per2;
            if (!((r < u2) || (r > u2 + g2 && r < len2)))
                return 0;
        end
        pix = 8'(p2 / (2 * longint'(pitch)));
        return 1;
    endfunction

    function automatic shadow_t predict_shadow(input logic [8:0] c, input logic [8:0] rw,
                                               input logic [15:0] tr);
        shadow_t s;
        logic [7:0] px;
        logic [7:0] py;
        bit ok;
        s = '0;
        ok = (c < MASK_SIZE) && (rw < MASK_SIZE);
        if (ok)
            ok = axis_shadow(c, m_pitch_x, m_off_x, px);
        if (ok)
            ok = axis_shadow(rw, m_pitch_y, m_off_y, py);
        if (ok)
        begin
            s.col = px;
            s.row = py;
            s.hit = 1;
            s.value = tr;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Check each result against the oldest prediction
    always @(posedge clk)
    begin
        shadow_t want;
        if (rst_n && done)
        begin
            shadows_seen++;
            if (expected_shadows.size() == 0)
                report_mismatch("unexpected result, hit", hit, 0);
            else
            begin
                want = expected_shadows.pop_front();
                if (hit) hits_seen++;
                if (det_col !== want.col) report_mismatch("det_col", det_col, want.col);
                if (det_row !== want.row) report_mismatch("det_row", det_row, want.row);
                if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
                if (shadow_value !== want.value)
                    report_mismatch("shadow_value", shadow_value, want.value);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (start && !busy || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_pixel(input logic [8:0] c, input logic [8:0] rw, input logic [15:0] tr);
        int gap;
        // Hold off the sender for a random burst
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        mask_col <= c;
        mask_row <= rw;
        transparency <= tr;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_shadows.push_back(predict_shadow(c, rw, tr));
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 0;
        @(posedge clk);
        while (expected_shadows.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Write one register; the caller drops the write enable afterwards
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_PITCH_X:     m_pitch_x = val[23:0];
            REG_PITCH_Y:     m_pitch_y = val[23:0];
            REG_OFFSET_X:    m_off_x = val;
            REG_OFFSET_Y:    m_off_y = val;
            REG_UNIT_LENGTH: m_unit_len = val[29:0];
            REG_UNIT_GAP:    m_unit_gap = val[29:0];
            REG_MODULE_GAP:  m_mod_gap = val[29:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [23:0] px, input logic [23:0] py,
                                input logic [31:0] ox, input logic [31:0] oy,
                                input logic [29:0] ul, input logic [29:0] ug,
                                input logic [29:0] mg);
        write_reg(REG_PITCH_X, 32'(px));
        write_reg(REG_PITCH_Y, 32'(py));
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_UNIT_LENGTH, 32'(ul));
        write_reg(REG_UNIT_GAP, 32'(ug));
        write_reg(REG_MODULE_GAP, 32'(mg));
        cfg_we <= 0;
    endtask

    task automatic random_pixels(input int count);
        repeat (count)
            send_pixel(9'($urandom), 9'($urandom), 16'($urandom));
    endtask

    // Extremes of the fields, edges of the detector, reset registers
    task automatic test_directed();
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(511, 511, 0);
        send_pixel(255, 255, 16'h5555);
        send_pixel(256, 0, 16'hAAAA);
        send_pixel(0, 256, 1);
        send_pixel(128, 300, 16'h8000);
        drain_results();
        // Position exactly at the right edge: offset pulls pixel 255 onto it
        set_geometry(1000, 1000, 500, -500, 0, 0, 0);
        send_pixel(255, 0, 7);
        send_pixel(254, 0, 8);
        send_pixel(0, 0, 9);
        send_pixel(0, 1, 10);
        drain_results();
        // Zero pitch misses everywhere
        set_geometry(0, 0, 0, 0, 0, 0, 0);
        send_pixel(0, 0, 11);
        send_pixel(100, 100, 12);
        drain_results();
        // Gap boundaries: unit 10, unit gap 4, module gap 6, positions on even nm
        set_geometry(2, 2, -1, -1, 10, 4, 6);
        for (int i = 0; i < 16; i++)
            send_pixel(9'(i), 9'(i), 16'(i));
        drain_results();
    endtask

    task automatic test_extremes();
        set_geometry(24'hFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                     30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF);
        random_pixels(60);
        drain_results();
        set_geometry(24'hFFFFFF, 1, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0);
        random_pixels(60);
        drain_results();
        set_geometry(1, 24'hFFFFFF, 32'hFFFFFFFF, 0, 1, 0, 0);
        random_pixels(60);
        drain_results();
    endtask

    // Random geometries chosen so that most pixels land on the detector
    task automatic test_random_geometry();
        logic [23:0] px;
        logic [23:0] py;
        int span;
        for (int ph = 0; ph < 24; ph++)
        begin
            px = ph % 6 == 0 ? 24'($urandom) : 24'($urandom_range(1, 4000));
            py = ph % 6 == 1 ? 24'($urandom) : 24'($urandom_range(1, 4000));
            span = int'(px) * 64;
            set_geometry(px, py,
                ph % 5 == 0 ? $urandom : -$urandom_range(0, span),
                ph % 5 == 1 ? $urandom : -$urandom_range(0, int'(py) * 64),
                ph % 3 == 0 ? 30'($urandom) :
                    (ph % 3 == 1 ? 30'(0) : 30'($urandom_range(1, 20000))),
                30'($urandom_range(0, 3000)) | (ph == 7 ? 30'h3FFFFFFF : 30'(0)),
                30'($urandom_range(0, 5000)) | (ph == 8 ? 30'h3FFFFFFF : 30'(0)));
            if (ph == 20) allow_gaps = 0;
            random_pixels(70);
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        mask_col = 0;
        mask_row = 0;
        transparency = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_data = 0;
        mismatches = 0;
        hits_seen = 0;
        shadows_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        timed_out = 0;
        allow_gaps = 1;
        m_pitch_x = 250000;
        m_pitch_y = 250000;
        m_off_x = 0;
        m_off_y = 0;
        m_unit_len = 0;
        m_unit_gap = 0;
        m_mod_gap = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_extremes();
        test_random_geometry();
        drain_results();
        $display("tb: sent %0d pixels, %0d results checked, %0d hits, over 30 geometries",
                 items_sent, shadows_seen, hits_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/msp_pkg.sv
src/msp_axis.sv
src/mask_shadow_projection.sv
tb/mask_shadow_projection_tb.sv
